>>> rtl/core/flat_earth_waypoint_bearing_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the waypoint bearing unit
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ---------------------------------------------------------------------------
`ifndef FLAT_EARTH_WAYPOINT_BEARING_UNIT_ASSERT_SVH
`define FLAT_EARTH_WAYPOINT_BEARING_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FEWB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FEWB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/fewb_pkg.sv
// ---------------------------------------------------------------------------
// fewb_pkg
// Widths, constants, arctangent table and queue item type shared by the
// waypoint bearing unit.
// ---------------------------------------------------------------------------
package fewb_pkg;

	// field widths
	localparam int unsigned LAT_W      = 31;
	localparam int unsigned LON_W      = 32;
	localparam int unsigned DLAT_W     = 32;
	localparam int unsigned DLON_W     = 33;
	localparam int unsigned BEAR_W     = 17;
	localparam int unsigned S_TDATA_W  = 128;
	localparam int unsigned M_TDATA_W  = 24;

	// cordic datapath
	localparam int unsigned ANG_W      = 32;
	localparam int unsigned VEC_W      = 60;
	localparam int unsigned PRESCALE   = 24;
	localparam int unsigned PROD_W     = 48;
	localparam int unsigned HUND_W     = 16;

	localparam int unsigned CORDIC_STAGES_DEF = 20;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;

	// binary angle constants (2^32 per turn)
	localparam logic [ANG_W-1:0] ANG_QUARTER = 32'h4000_0000;
	localparam logic [ANG_W-1:0] ANG_HALF    = 32'h8000_0000;

	// hundredths of a degree
	localparam logic [HUND_W-1:0] TURN_HUND = 16'd36000;
	localparam logic [HUND_W-1:0] HALF_HUND = 16'd18000;
	localparam logic [PROD_W-1:0] ROUND_HALF = 48'h0000_8000_0000;

	// atan(2^-i) in binary angle units, rounded
	localparam logic [ANG_W-1:0] ATAN_LUT [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// classified item handed from front to back
	typedef struct packed {
		logic [DLAT_W-1:0] dlat;
		logic [DLON_W-1:0] dlon;
		logic              flip;
		logic              zero;
	} fewb_item_t;

endpackage

>>> rtl/core/fewb_front.sv
// ---------------------------------------------------------------------------
// fewb_front
// Input side: takes position pairs, forms exact deltas and classifies the
// vector (left half-plane, zero length) before queueing it.
// ---------------------------------------------------------------------------
module fewb_front (
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [fewb_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                q_full,
	output logic                                push,
	output fewb_pkg::fewb_item_t                item
);
	import fewb_pkg::*;

	logic [LAT_W-1:0] from_lat;
	logic [LON_W-1:0] from_lon;
	logic [LAT_W-1:0] to_lat;
	logic [LON_W-1:0] to_lon;

	// unpack the transaction
	assign from_lat = s_axis_tdata[LAT_W-1:0];
	assign from_lon = s_axis_tdata[LAT_W+LON_W-1:LAT_W];
	assign to_lat   = s_axis_tdata[2*LAT_W+LON_W-1:LAT_W+LON_W];
	assign to_lon   = s_axis_tdata[2*LAT_W+2*LON_W-1:2*LAT_W+LON_W];

	// accept whenever the queue has room
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	// exact deltas and classification
	always_comb begin
		item.dlat = {to_lat[LAT_W-1], to_lat} - {from_lat[LAT_W-1], from_lat};
		item.dlon = {to_lon[LON_W-1], to_lon} - {from_lon[LON_W-1], from_lon};
		item.flip = item.dlon[DLON_W-1];
		item.zero = (item.dlat == '0) && (item.dlon == '0);
	end

endmodule

>>> rtl/core/fewb_queue.sv
// ---------------------------------------------------------------------------
// fewb_queue
// Short first-in first-out queue of classified items between front and back.
// ---------------------------------------------------------------------------
module fewb_queue #(
	parameter int unsigned DEPTH = fewb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fewb_pkg::fewb_item_t wr_item,
	input  logic                 pop,
	output fewb_pkg::fewb_item_t rd_item,
	output logic                 full,
	output logic                 not_empty
);
	import fewb_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	fewb_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> rtl/core/fewb_back.sv
// ---------------------------------------------------------------------------
// fewb_back
// Execution side: pipelined vectoring cordic, compass conversion to
// hundredths of a degree, and the output register.
// ---------------------------------------------------------------------------
module fewb_back #(
	parameter int unsigned STAGES = fewb_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           bipolar_mode,
	input  logic                           q_valid,
	input  fewb_pkg::fewb_item_t           q_item,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [fewb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import fewb_pkg::*;

	// whole pipeline moves when the output register is free or being taken
	logic adv;

	logic                    valid_s1;
	logic signed [VEC_W-1:0] x_s1;
	logic signed [VEC_W-1:0] y_s1;
	logic [ANG_W-1:0]        z_s1;
	logic                    zero_s1;

	logic                    valid_s2 [STAGES];
	logic signed [VEC_W-1:0] x_s2     [STAGES];
	logic signed [VEC_W-1:0] y_s2     [STAGES];
	logic [ANG_W-1:0]        z_s2     [STAGES];
	logic                    zero_s2  [STAGES];

	logic                    valid_s3;
	logic [PROD_W-1:0]       prod_s3;

	logic                    valid_s4;
	logic [BEAR_W-1:0]       bearing_s4;

	logic signed [VEC_W-1:0] dlon_ext;
	logic signed [VEC_W-1:0] dlat_ext;
	logic [ANG_W-1:0]        angle_c;
	logic [ANG_W-1:0]        b_c;
	logic [PROD_W-1:0]       rnd_c;
	logic [HUND_W-1:0]       hund_c;
	logic [BEAR_W-1:0]       bear_c;

	assign adv = !valid_s4 || m_axis_tready;
	assign pop = adv && q_valid;

	// stage 1: fold into the right half-plane and prescale
	assign dlon_ext = {{(VEC_W-DLON_W){q_item.dlon[DLON_W-1]}}, q_item.dlon};
	assign dlat_ext = {{(VEC_W-DLAT_W){q_item.dlat[DLAT_W-1]}}, q_item.dlat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= (q_item.flip ? -dlon_ext : dlon_ext) <<< PRESCALE;
			y_s1    <= (q_item.flip ? -dlat_ext : dlat_ext) <<< PRESCALE;
			z_s1    <= q_item.flip ? ANG_HALF : '0;
			zero_s1 <= q_item.zero;
		end
	end

	// stage 2: one micro-rotation per pipeline stage
	for (genvar g = 0; g < STAGES; g++) begin : g_rot
		logic                    vi;
		logic signed [VEC_W-1:0] xi;
		logic signed [VEC_W-1:0] yi;
		logic [ANG_W-1:0]        zi;
		logic                    zri;

		if (g == 0) begin : g_first
			assign vi  = valid_s1;
			assign xi  = x_s1;
			assign yi  = y_s1;
			assign zi  = z_s1;
			assign zri = zero_s1;
		end else begin : g_next
			assign vi  = valid_s2[g-1];
			assign xi  = x_s2[g-1];
			assign yi  = y_s2[g-1];
			assign zi  = z_s2[g-1];
			assign zri = zero_s2[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[g] <= 1'b0;
			end else if (adv) begin
				valid_s2[g] <= vi;
			end
		end

		// drive y toward zero, accumulate the angle turned
		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s2[g] <= zri;
				if (!yi[VEC_W-1]) begin
					x_s2[g] <= xi + (yi >>> g);
					y_s2[g] <= yi - (xi >>> g);
					z_s2[g] <= zi + ATAN_LUT[g];
				end else begin
					x_s2[g] <= xi - (yi >>> g);
					y_s2[g] <= yi + (xi >>> g);
					z_s2[g] <= zi - ATAN_LUT[g];
				end
			end
		end
	end

	// stage 3: compass angle times one turn in hundredths
	assign angle_c = zero_s2[STAGES-1] ? '0 : z_s2[STAGES-1];
	assign b_c     = ANG_QUARTER - angle_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= PROD_W'(b_c) * PROD_W'(TURN_HUND);
		end
	end

	// stage 4: round, wrap full turn, optional signed range
	assign rnd_c  = prod_s3 + ROUND_HALF;
	assign hund_c = rnd_c[PROD_W-1:PROD_W-HUND_W];

	always_comb begin
		priority if (hund_c >= TURN_HUND) begin
			bear_c = '0;
		end else if (bipolar_mode && (hund_c > HALF_HUND)) begin
			bear_c = {1'b0, hund_c} - {1'b0, TURN_HUND};
		end else begin
			bear_c = {1'b0, hund_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bearing_s4 <= bear_c;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {{(M_TDATA_W-BEAR_W){1'b0}}, bearing_s4};

endmodule

>>> rtl/core/flat_earth_waypoint_bearing_unit.sv
// ---------------------------------------------------------------------------
// flat_earth_waypoint_bearing_unit
// Compass bearing between two fixed-point positions on a flat earth model,
// via a pipelined vectoring cordic, in hundredths of a degree.
// ---------------------------------------------------------------------------
//
//  channel     dir  width  contents (low bit up)
//  s_axis      in   128    from_lat[30:0] from_lon[62:31] to_lat[93:63]
//                          to_lon[125:94], zero fill
//  m_axis      out  24     bearing[16:0] signed, zero fill
//  bipolar_mode in  1      write enable plus data, takes effect next cycle
//
//  one transaction per cycle in and out when nothing stalls
//  a result is registered at the queue write, fold/prescale, each cordic
//  stage, multiply, and round and output register
//  reset clears the queue count and all stage valids; payloads are not reset
//  a stalled output freezes the back pipeline; the 4-entry queue keeps
//  s_axis ready until it fills
//
module flat_earth_waypoint_bearing_unit #(
	parameter int unsigned CORDIC_STAGES = fewb_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// from_lat, from_lon, to_lat, to_lon
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [fewb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// bearing
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [fewb_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic                           bipolar_mode_we,
	input  logic                           bipolar_mode_wdata
);
	import fewb_pkg::*;

	logic       bipolar_mode_q;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_valid;
	fewb_item_t front_item;
	fewb_item_t queue_item;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bipolar_mode_q <= 1'b0;
		end else if (bipolar_mode_we) begin
			bipolar_mode_q <= bipolar_mode_wdata;
		end
	end

	// accept and classify
	fewb_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.push          (push),
		.item          (front_item)
	);

	// decoupling queue
	fewb_queue #(
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (front_item),
		.pop       (pop),
		.rd_item   (queue_item),
		.full      (q_full),
		.not_empty (q_valid)
	);

	// cordic and conversion
	fewb_back #(
		.STAGES (CORDIC_STAGES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bipolar_mode  (bipolar_mode_q),
		.q_valid       (q_valid),
		.q_item        (queue_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> rtl/core/fewb_checker.sv
// ---------------------------------------------------------------------------
// fewb_checker
// Port-level checks on the waypoint bearing unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "flat_earth_waypoint_bearing_unit_assert.svh"

module fewb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [fewb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [fewb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import fewb_pkg::*;

	logic signed [BEAR_W-1:0] bearing;
	logic                     in_xact;

	assign bearing = m_axis_tdata[BEAR_W-1:0];
	assign in_xact = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0);

	// a stalled result stays offered and unchanged
	`FEWB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`FEWB_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

	// bearing lies in the union of both output ranges and never shows a full turn
	`FEWB_ASSERT_SAME(a_bear_range, m_axis_tvalid, (bearing <= 17'sd35999) && (bearing >= -17'sd17999), "bearing out of range")

	// fill bits above the bearing stay zero
	`FEWB_ASSERT_SAME(a_fill_zero, m_axis_tvalid || in_xact, m_axis_tdata[M_TDATA_W-1:BEAR_W] == '0, "nonzero fill in result")

endmodule

bind flat_earth_waypoint_bearing_unit fewb_checker u_fewb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
